// File: rtl/rsm_pkg.sv
// ----------------------------------------------------------------------------
// rsm_pkg
// shared types and constants of the rumble effect slot manager
// ----------------------------------------------------------------------------
package rsm_pkg;

  // request codes
  localparam logic [1:0] REQ_UPLOAD = 2'd0;
  localparam logic [1:0] REQ_ERASE  = 2'd1;
  localparam logic [1:0] REQ_PLAY   = 2'd2;
  localparam logic [1:0] REQ_TICK   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NO_SLOT = 2'd2;

  localparam logic [15:0] RUMBLE_CODE = 16'h0050;
  localparam logic [15:0] FULL_GAIN   = 16'hFFFF;

  localparam int EFFECT_W = 48;

  // request to the shared multiplier
  typedef struct packed {
    logic        en;
    logic [15:0] a;
    logic [15:0] b;
  } mul_req_t;

endpackage

// File: rtl/rsm_ram.sv
// ----------------------------------------------------------------------------
// rsm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module rsm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rsm_mul.sv
// ----------------------------------------------------------------------------
// rsm_mul
// shared 16x16 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module rsm_mul (
  input  logic              clk,
  input  rsm_pkg::mul_req_t req,
  output logic [31:0]       prod
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= {16'b0, req.a} * {16'b0, req.b};
    end
  end

endmodule

// File: rtl/rumble_effect_slot_manager.sv
// ----------------------------------------------------------------------------
// rumble_effect_slot_manager
// rumble effect table with gain scaling and a millisecond motor countdown
// ----------------------------------------------------------------------------
// One request word is handled at a time. Erase, tick and upload to a named
// slot go from the decode step straight to the finishing step. Upload to
// the first free slot walks the used flags one slot per cycle and looks at
// no more than MAX_EFFECTS slots. Play reads the effect table, then uses
// the one shared multiplier twice (magnitude times gain, then length times
// repeats). The block takes a new word as soon as its sequencer is idle,
// even while the previous result word is still waiting at the output.
module rumble_effect_slot_manager #(
  parameter int MAX_EFFECTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [15:0]       effect_type,
  input  logic signed [8:0] slot_id,
  input  logic [15:0]       strong_mag,
  input  logic [15:0]       weak_mag,
  input  logic [15:0]       length_ms,
  input  logic signed [8:0] repeat_count,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [3:0]        assigned_slot,
  output logic              motor_on,
  output logic [15:0]       scaled_mag,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int SW = (MAX_EFFECTS > 1) ? $clog2(MAX_EFFECTS) : 1;
  localparam logic [7:0]    MAX8 = 8'(MAX_EFFECTS);
  localparam logic [SW-1:0] LAST = SW'(MAX_EFFECTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_RDWAIT,
    S_MUL1,
    S_MUL2,
    S_DONE
  } state_t;

  state_t state;

  logic [15:0] gain;

  // latched request word
  logic [1:0]  rq_type;
  logic [15:0] rq_etype;
  logic [8:0]  rq_slot;
  logic [15:0] rq_strong;
  logic [15:0] rq_weak;
  logic [15:0] rq_len;
  logic [8:0]  rq_rep;

  logic [MAX_EFFECTS-1:0] slot_used;
  logic                   motor_active;
  logic [23:0]            remaining_ms;

  logic [SW-1:0] scan_idx;
  logic [15:0]   e_len;

  logic [1:0]  res_status;
  logic [3:0]  res_slot;
  logic [15:0] res_scaled;

  logic [SW-1:0]                id_idx;
  logic                         id_ok;
  logic                         ram_we;
  logic [SW-1:0]                ram_waddr;
  logic [rsm_pkg::EFFECT_W-1:0] ram_rdata;
  rsm_pkg::mul_req_t            mul_req;
  logic [31:0]                  prod;
  logic [32:0]                  div_sum;
  logic [15:0]                  rd_max;
  logic [7:0]                   reps;
  logic [23:0]                  rem_dec;
  logic                         cfg_wr;

  function automatic logic [3:0] slot4(input logic [SW-1:0] idx);
    logic [7:0] w;
    w = 8'(idx);
    return w[3:0];
  endfunction

  assign in_ready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && !paddr[2];
  assign prdata   = paddr[2] ? 32'b0 : {16'b0, gain};

  assign id_idx = rq_slot[SW-1:0];
  assign id_ok  = !rq_slot[8] && (rq_slot[7:0] < MAX8);

  assign ram_we = ((state == S_DECODE) && (rq_type == rsm_pkg::REQ_UPLOAD) &&
                   (rq_etype == rsm_pkg::RUMBLE_CODE) && id_ok) ||
                  ((state == S_SCAN) && !slot_used[scan_idx]);
  assign ram_waddr = (state == S_SCAN) ? scan_idx : id_idx;

  rsm_ram #(
    .WIDTH (rsm_pkg::EFFECT_W),
    .DEPTH (MAX_EFFECTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({rq_strong, rq_weak, rq_len}),
    .raddr (id_idx),
    .rdata (ram_rdata)
  );

  // table word: strong, weak, length
  assign rd_max = (ram_rdata[31:16] > ram_rdata[47:32]) ? ram_rdata[31:16]
                                                        : ram_rdata[47:32];
  assign reps   = (rq_rep[8] || (rq_rep == 9'd0)) ? 8'd1 : rq_rep[7:0];

  always_comb begin
    mul_req.en = 1'b0;
    mul_req.a  = rd_max;
    mul_req.b  = gain;
    if (state == S_RDWAIT) begin
      mul_req.en = 1'b1;
    end else if (state == S_MUL1) begin
      mul_req.en = 1'b1;
      mul_req.a  = e_len;
      mul_req.b  = {8'b0, reps};
    end
  end

  rsm_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // exact floor(p / 65535) for p up to 65535 * 65535
  assign div_sum = {1'b0, prod} + {17'b0, prod[31:16]} + 33'd1;
  assign rem_dec = (remaining_ms != 24'd0) ? remaining_ms - 24'd1 : 24'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      motor_active <= 1'b0;
      remaining_ms <= '0;
      slot_used    <= '0;
      gain         <= rsm_pkg::FULL_GAIN;
    end else begin
      if (cfg_wr) begin
        gain <= pwdata[15:0];
      end
      // the finishing step handles the output valid on its own
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rq_type    <= req_type;
            rq_etype   <= effect_type;
            rq_slot    <= slot_id;
            rq_strong  <= strong_mag;
            rq_weak    <= weak_mag;
            rq_len     <= length_ms;
            rq_rep     <= repeat_count;
            res_status <= rsm_pkg::ST_OK;
            res_slot   <= 4'd0;
            res_scaled <= 16'd0;
            state      <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_DONE;
          unique case (rq_type)
            rsm_pkg::REQ_UPLOAD: begin
              if (rq_etype != rsm_pkg::RUMBLE_CODE) begin
                res_status <= rsm_pkg::ST_INVALID;
              end else if (rq_slot[8]) begin
                scan_idx <= '0;
                state    <= S_SCAN;
              end else if (!id_ok) begin
                res_status <= rsm_pkg::ST_INVALID;
              end else begin
                slot_used[id_idx] <= 1'b1;
                res_slot          <= slot4(id_idx);
              end
            end
            rsm_pkg::REQ_ERASE: begin
              if (!id_ok) begin
                res_status <= rsm_pkg::ST_INVALID;
              end else begin
                slot_used[id_idx] <= 1'b0;
                motor_active      <= 1'b0;
                remaining_ms      <= '0;
              end
            end
            rsm_pkg::REQ_PLAY: begin
              if (!id_ok || !slot_used[id_idx]) begin
                res_status <= rsm_pkg::ST_INVALID;
              end else begin
                state <= S_RDWAIT;
              end
            end
            default: begin
              if (motor_active) begin
                remaining_ms <= rem_dec;
                if (rem_dec == 24'd0) begin
                  motor_active <= 1'b0;
                end
              end
            end
          endcase
        end
        S_SCAN: begin
          if (!slot_used[scan_idx]) begin
            slot_used[scan_idx] <= 1'b1;
            res_slot            <= slot4(scan_idx);
            state               <= S_DONE;
          end else if (scan_idx == LAST) begin
            res_status <= rsm_pkg::ST_NO_SLOT;
            state      <= S_DONE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_RDWAIT: begin
          e_len <= ram_rdata[15:0];
          state <= S_MUL1;
        end
        S_MUL1: begin
          res_scaled <= div_sum[31:16];
          state      <= S_MUL2;
        end
        S_MUL2: begin
          if ((res_scaled == 16'd0) || (rq_rep == 9'd0)) begin
            motor_active <= 1'b0;
            remaining_ms <= '0;
          end else begin
            motor_active <= 1'b1;
            remaining_ms <= prod[23:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            status        <= res_status;
            assigned_slot <= res_slot;
            motor_on      <= motor_active;
            scaled_mag    <= res_scaled;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a stopped motor never keeps a countdown
  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    !motor_active |-> (remaining_ms == 24'd0))
    else $error("motor off with nonzero countdown");

  // a result word only appears from the finishing step
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result word raised outside finishing step");

  // one word in flight at a time
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new word taken while busy");

  // the free slot walk only runs for uploads without a named slot
  a_scan_auto: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (rq_slot[8] && (rq_type == rsm_pkg::REQ_UPLOAD)))
    else $error("slot walk for a named request");

endmodule
